[rtl/qtncm_pkg.sv]
// Package: shared widths, rate constants, node record type and saturation helper.
package qtncm_pkg;

  localparam int unsigned CellW     = 24;
  localparam int unsigned DistW     = 32;
  localparam int unsigned RateW     = 16;
  localparam int unsigned LambdaW   = 16;
  localparam int unsigned LambdaFrac = 8;

  localparam logic [LambdaW-1:0] LambdaReset = 16'd256;
  localparam logic [RateW-1:0]   LeafRate    = 16'd3;
  localparam logic [RateW-1:0]   NodeRate    = 16'd11;

  // Node result handed from the accumulator to the decision pipeline
  typedef struct packed {
    logic signed [DistW-1:0] ref_dist;
    logic signed [DistW-1:0] split_dist;
    logic [RateW-1:0]        rate;
    logic                    finest;
  } node_t;

  // Clamp a 34-bit signed sum into the 32-bit signed range
  function automatic logic signed [DistW-1:0] sat_dist(input logic signed [DistW+1:0] v);
    logic signed [DistW-1:0] res;
    if ((v[DistW+1] == v[DistW]) && (v[DistW] == v[DistW-1])) begin
      res = v[DistW-1:0];
    end else if (v[DistW+1]) begin
      res = {1'b1, {(DistW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DistW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

[rtl/qtncm_accum.sv]
// Child accumulator: running saturated sums and the node record register.
module qtncm_accum import qtncm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     finest_i,
  input  logic signed [CellW-1:0]  cell_dist_i,
  input  logic signed [DistW-1:0]  child_ref_dist_i,
  input  logic signed [DistW-1:0]  child_split_dist_i,
  input  logic [RateW-1:0]         child_rate_i,
  input  logic                     last_i,
  output node_t                    node_o,
  output logic                     node_valid_o,
  input  logic                     node_ready_i
);

  logic signed [DistW-1:0] ref_sum_q, ref_sum_d;
  logic signed [DistW-1:0] split_sum_q, split_sum_d;
  logic [RateW-1:0]        rate_sum_q, rate_sum_d;
  logic                    node_valid_q;
  node_t                   node_q;

  logic                    accept;
  logic signed [DistW:0]   cell_ext, cell_neg, cref_ext, cref_neg, csplit_ext;
  logic signed [DistW:0]   ref_add, split_add, child_split_part;
  logic [RateW:0]          rate_acc, rate_node;
  logic [RateW-1:0]        node_rate;

  assign in_ready_o   = !node_valid_q || node_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign node_o       = node_q;
  assign node_valid_o = node_valid_q;

  // Per-child contributions, 33 bits signed
  always_comb begin
    cell_ext   = {{(DistW+1-CellW){cell_dist_i[CellW-1]}}, cell_dist_i};
    cell_neg   = cell_dist_i[CellW-1] ? cell_ext : '0;
    cref_ext   = {child_ref_dist_i[DistW-1], child_ref_dist_i};
    cref_neg   = child_ref_dist_i[DistW-1] ? cref_ext : '0;
    csplit_ext = {child_split_dist_i[DistW-1], child_split_dist_i};
    // a splitting child brings its own split distance, a leaf its negative part
    child_split_part = (child_rate_i != '0) ? csplit_ext : cref_neg;
    if (finest_i) begin
      ref_add   = cell_ext;
      split_add = cell_neg;
    end else begin
      ref_add   = cell_ext + cref_ext;
      split_add = cell_neg + child_split_part;
    end
  end

  // Saturated sums including this child
  always_comb begin
    ref_sum_d   = sat_dist({{2{ref_sum_q[DistW-1]}}, ref_sum_q} + {ref_add[DistW], ref_add});
    split_sum_d = sat_dist({{2{split_sum_q[DistW-1]}}, split_sum_q}
                           + {split_add[DistW], split_add});
    rate_acc    = {1'b0, rate_sum_q} + {1'b0, child_rate_i};
    if (finest_i) begin
      rate_sum_d = rate_sum_q;
    end else begin
      rate_sum_d = rate_acc[RateW] ? '1 : rate_acc[RateW-1:0];
    end
    rate_node = {1'b0, rate_sum_d} + {1'b0, NodeRate};
    if (finest_i) begin
      node_rate = LeafRate;
    end else begin
      node_rate = rate_node[RateW] ? '1 : rate_node[RateW-1:0];
    end
  end

  // Running sums, cleared at the end of each node
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_sum_q    <= '0;
      split_sum_q  <= '0;
      rate_sum_q   <= '0;
      node_valid_q <= 1'b0;
    end else begin
      // a new node record replaces one that leaves, otherwise an unread one holds
      node_valid_q <= (accept && last_i) || (node_valid_q && !node_ready_i);
      if (accept) begin
        if (last_i) begin
          ref_sum_q    <= '0;
          split_sum_q  <= '0;
          rate_sum_q   <= '0;
        end else begin
          ref_sum_q   <= ref_sum_d;
          split_sum_q <= split_sum_d;
          rate_sum_q  <= rate_sum_d;
        end
      end
    end
  end

  // Node record, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      node_q.ref_dist   <= ref_sum_d;
      node_q.split_dist <= split_sum_d;
      node_q.rate       <= node_rate;
      node_q.finest     <= finest_i;
    end
  end

endmodule

[rtl/quadtree_node_cost_merge.sv]
// Top level: quadtree node cost merge with rate-distortion split decision.
// A node word passes through the node register, the lambda product register and
// the output register after its group_last child is accepted.
// Throughput: one child word and one node word per cycle while nothing stalls.
// A stage stalls only while the stage after it holds a stalled word; children
// without group_last only update the running sums. Reset clears the sums, all
// valid flags and sets lambda to 1.0 (256 in Q8.8).
module quadtree_node_cost_merge import qtncm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration: lambda, unsigned Q8.8
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  // child words
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [23:0] cell_dist, [55:24] child_ref_dist, [87:56] child_split_dist,
  // [103:88] child_rate
  input  logic [103:0]  s_axis_tdata,
  // [0] finest_level
  input  logic          s_axis_tuser,
  input  logic          s_axis_tlast,
  // node words
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] ref_dist, [63:32] split_dist, [79:64] node_rate
  output logic [79:0]   m_axis_tdata
);

  logic [LambdaW-1:0]          lambda_q;
  node_t                       node;
  logic                        node_valid, node_ready;
  logic                        prod_valid_q, out_valid_q;
  logic                        out_ready;
  logic signed [DistW:0]       gain;
  logic signed [LambdaW+DistW:0] prod_d, prod_q;
  node_t                       node2_q;
  logic signed [LambdaW+DistW+1:0] cost;
  logic                        keep;
  logic signed [DistW-1:0]     ref_out_q, split_out_q;
  logic [RateW-1:0]            rate_out_q;

  // Lambda register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= LambdaReset;
    end else if (cfg_we_i) begin
      lambda_q <= cfg_wdata_i;
    end
  end

  qtncm_accum u_accum (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .finest_i           (s_axis_tuser),
    .cell_dist_i        (s_axis_tdata[23:0]),
    .child_ref_dist_i   (s_axis_tdata[55:24]),
    .child_split_dist_i (s_axis_tdata[87:56]),
    .child_rate_i       (s_axis_tdata[103:88]),
    .last_i             (s_axis_tlast),
    .node_o             (node),
    .node_valid_o       (node_valid),
    .node_ready_i       (node_ready)
  );

  // Stall chain
  assign out_ready  = !out_valid_q || m_axis_tready;
  assign node_ready = !prod_valid_q || out_ready;

  // Split gain times lambda
  always_comb begin
    gain   = {node.split_dist[DistW-1], node.split_dist}
             - (node.ref_dist[DistW-1] ? {node.ref_dist[DistW-1], node.ref_dist} : '0);
    prod_d = $signed({1'b0, lambda_q}) * gain;
  end

  // Rate plus weighted gain, strict test at the finest level
  always_comb begin
    cost = {{(LambdaW+DistW+2-RateW-LambdaFrac){1'b0}}, node2_q.rate, {LambdaFrac{1'b0}}}
           + {prod_q[LambdaW+DistW], prod_q};
    if (node2_q.finest) begin
      keep = cost[LambdaW+DistW+1];
    end else begin
      keep = cost[LambdaW+DistW+1] || (cost == '0);
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (node_ready) begin
        prod_valid_q <= node_valid;
      end
      if (out_ready) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (node_ready && node_valid) begin
      prod_q  <= prod_d;
      node2_q <= node;
    end
    if (out_ready && prod_valid_q) begin
      ref_out_q   <= node2_q.ref_dist;
      split_out_q <= node2_q.split_dist;
      rate_out_q  <= keep ? node2_q.rate : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {rate_out_q, split_out_q, ref_out_q};

endmodule

[rtl/qtncm_checker.sv]
// Port-level checker for the node cost merge, bound to the top level.
module qtncm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic          s_axis_tlast,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [79:0]   m_axis_tdata
);

  logic [2:0] pend_q;
  logic       node_in, node_out;

  assign node_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign node_out = m_axis_tvalid && m_axis_tready;

  // Nodes in flight between a group_last child and its output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, node_in} - {2'b00, node_out};
    end
  end

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // no node word without a closed group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("node word without a group_last child");

  // at most three nodes in the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("too many nodes in flight");

  // a kept rate is the leaf rate or at least the node rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[79:64] == 16'd0) || (m_axis_tdata[79:64] == 16'd3)
                      || (m_axis_tdata[79:64] >= 16'd11))
    else $error("node rate out of range");

endmodule

bind quadtree_node_cost_merge qtncm_checker u_checker (.*);

[tb/sv/quadtree_node_cost_merge_tb.sv]
// Testbench for quadtree_node_cost_merge: random and directed children, predicted node words.
module quadtree_node_cost_merge_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qtncm_pkg::*;

  // One child word as the sender sees it
  typedef struct packed {
    logic             finest;
    logic [CellW-1:0] cell_dist;
    logic [DistW-1:0] cref;
    logic [DistW-1:0] csplit;
    logic [RateW-1:0] crate;
    logic             last;
  } child_t;

  // Node word, laid out exactly as m_axis_tdata (ref_dist in the low bits)
  typedef struct packed {
    logic [RateW-1:0] node_rate;
    logic [DistW-1:0] split_dist;
    logic [DistW-1:0] ref_dist;
  } node_word_t;

  // Running node sums, lambda copy and the queue of node words still due
  class node_cost_tracker;
    longint             ref_acc;
    longint             split_acc;
    longint             rate_acc;
    logic [LambdaW-1:0] lambda_q;
    node_word_t         pending_nodes[$];
    int                 errors;

    function new();
      ref_acc   = 0;
      split_acc = 0;
      rate_acc  = 0;
      lambda_q  = LambdaReset;
      errors    = 0;
    endfunction

    function longint neg_part(longint v);
      return (v < 0) ? v : 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    // Fold one accepted child into the sums; on the closing child queue the node word
    function void accept_child(child_t c);
      longint     cell_v;
      longint     cref_v;
      longint     radd;
      longint     sadd;
      longint     gap;
      longint     rate;
      logic       keep;
      node_word_t w;
      cell_v = longint'($signed(c.cell_dist));
      cref_v = longint'($signed(c.cref));
      radd   = cell_v;
      sadd   = neg_part(cell_v);
      if (!c.finest) begin
        radd += cref_v;
        sadd += (c.crate != 0) ? longint'($signed(c.csplit)) : neg_part(cref_v);
        rate_acc = rate_acc + longint'(c.crate);
        if (rate_acc > 65535) rate_acc = 65535;
      end
      ref_acc   = clamp32(ref_acc + radd);
      split_acc = clamp32(split_acc + sadd);
      if (!c.last) return;

      // split gain against the node's own negative part
      gap = split_acc - neg_part(ref_acc);
      if (c.finest) begin
        rate = longint'(LeafRate);
        keep = ((rate <<< LambdaFrac) + longint'(lambda_q) * gap) < 0;
      end else begin
        rate = longint'(NodeRate) + rate_acc;
        if (rate > 65535) rate = 65535;
        keep = ((rate <<< LambdaFrac) + longint'(lambda_q) * gap) <= 0;
      end
      w.ref_dist   = ref_acc[DistW-1:0];
      w.split_dist = split_acc[DistW-1:0];
      w.node_rate  = keep ? rate[RateW-1:0] : '0;
      pending_nodes.push_back(w);
      ref_acc   = 0;
      split_acc = 0;
      rate_acc  = 0;
    endfunction

    // Compare a delivered node word with the oldest one due
    task check_node(logic [79:0] data);
      node_word_t got;
      node_word_t want;
      got = node_word_t'(data);
      if (pending_nodes.size() == 0) begin
        report_mismatch("node word with none due, ref_dist", $signed(got.ref_dist), 0);
        return;
      end
      want = pending_nodes.pop_front();
      if (got.ref_dist !== want.ref_dist)
        report_mismatch("ref_dist", $signed(got.ref_dist), $signed(want.ref_dist));
      if (got.split_dist !== want.split_dist)
        report_mismatch("split_dist", $signed(got.split_dist), $signed(want.split_dist));
      if (got.node_rate !== want.node_rate)
        report_mismatch("node_rate", got.node_rate, want.node_rate);
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [LambdaW-1:0] cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [103:0]       s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [79:0]        m_axis_tdata;

  // 0: no idling, 1: sender idle 71%, 2: receiver stalls 71%, 3: both 6%
  int idle_mode = 0;
  node_cost_tracker tracker = new();

  always #5 clk_i = ~clk_i;

  quadtree_node_cost_merge u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Node side: check each accepted word, then draw the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_node(m_axis_tdata);
    case (idle_mode)
      2:       m_axis_tready <= ($urandom_range(0, 99) >= 71);
      3:       m_axis_tready <= ($urandom_range(0, 99) >= 6);
      default: m_axis_tready <= 1'b1;
    endcase
  end

  function automatic child_t mk_child(logic fin, int cd, int cr, int cs, int rt, logic lst);
    child_t c;
    c.finest    = fin;
    c.cell_dist = cd[CellW-1:0];
    c.cref      = cr;
    c.csplit    = cs;
    c.crate     = rt[RateW-1:0];
    c.last      = lst;
    return c;
  endfunction

  // Distances: full range, the extremes, or small values near zero
  function automatic logic [DistW-1:0] pick_dist();
    int v;
    case ($urandom_range(0, 5))
      0, 1:    v = $urandom;
      2:       v = 32'h7FFF_FFFF;
      3:       v = 32'h8000_0000;
      default: begin
        v = $urandom_range(0, 4000);
        v -= 2000;
      end
    endcase
    return v;
  endfunction

  function automatic logic [CellW-1:0] pick_cell();
    int v;
    case ($urandom_range(0, 5))
      0, 1:    v = $urandom;
      2:       v = 24'h7F_FFFF;
      3:       v = 24'h80_0000;
      default: begin
        v = $urandom_range(0, 600);
        v -= 300;
      end
    endcase
    return v[CellW-1:0];
  endfunction

  // Child rates: leaves are common, then small, full-range and maximum
  function automatic logic [RateW-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5, 6:    return RateW'($urandom_range(1, 64));
      7, 8:       return RateW'($urandom);
      default:    return '1;
    endcase
  endfunction

  // Present one child word and hold it until accepted
  task automatic send_child(input child_t c);
    while ((idle_mode == 1 && $urandom_range(0, 99) < 71) ||
           (idle_mode == 3 && $urandom_range(0, 99) < 6)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.crate, c.csplit, c.cref, c.cell_dist};
    s_axis_tuser  <= c.finest;
    s_axis_tlast  <= c.last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.accept_child(c);
  endtask

  // Stop sending and wait for every node word still due
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_nodes.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_lambda(input logic [LambdaW-1:0] value);
    hold_until_drained();
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.lambda_q = value;
  endtask

  // Mostly proper four-child groups; some short, long or of mixed levels
  task automatic send_group(output int n);
    child_t c;
    logic   broken;
    logic   fin;
    broken = ($urandom_range(0, 99) < 15);
    n      = broken ? $urandom_range(1, 7) : 4;
    fin    = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      c.finest    = broken ? 1'($urandom_range(0, 1)) : fin;
      c.cell_dist = pick_cell();
      c.cref      = pick_dist();
      c.csplit    = pick_dist();
      c.crate     = pick_rate();
      c.last      = (i == n - 1);
      send_child(c);
    end
  endtask

  initial begin
    int                 n;
    int                 sent;
    logic               paused;
    logic [LambdaW-1:0] lam;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // finest level, splitting pays by one step
    send_child(mk_child(1, 4, 0, 0, 0, 0));
    send_child(mk_child(1, -4, 0, 0, 0, 0));
    send_child(mk_child(1, 0, 0, 0, 0, 0));
    send_child(mk_child(1, 0, 0, 0, 0, 1));
    // finest level, cost equals gain: strict test drops the rate
    send_child(mk_child(1, 3, 0, 0, 0, 0));
    send_child(mk_child(1, -3, 0, 0, 0, 0));
    send_child(mk_child(1, 0, 0, 0, 0, 0));
    send_child(mk_child(1, 0, 0, 0, 0, 1));
    // coarser level, cost equals gain: non-strict test keeps the rate
    send_child(mk_child(0, 11, 0, 5, 0, 0));
    send_child(mk_child(0, -11, 0, -7, 0, 0));
    send_child(mk_child(0, 0, 0, 0, 0, 0));
    send_child(mk_child(0, 0, 0, 0, 0, 1));
    // sums and rate saturate
    send_child(mk_child(0, 8388607, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 0));
    send_child(mk_child(0, 8388607, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 0));
    send_child(mk_child(0, -8388608, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0));
    send_child(mk_child(0, 0, -1, -1, 0, 1));
    // one-child group
    send_child(mk_child(0, -8388608, 32'h8000_0000, 0, 0, 1));
    // six children, mixed levels, closed at the finest level
    send_child(mk_child(1, 8388607, -1, -1, 65535, 0));
    send_child(mk_child(0, 100, -500, -600, 7, 0));
    send_child(mk_child(0, -50, 300, -1000, 0, 0));
    send_child(mk_child(1, -8388608, 0, 0, 0, 0));
    send_child(mk_child(0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65535, 0));
    send_child(mk_child(1, -20, 0, 0, 0, 1));

    // random phases: lambda setting and idling pattern change per phase
    for (int phase = 0; phase < 8; phase++) begin
      if (phase != 0) begin
        case (phase)
          1:       lam = 16'd0;
          2:       lam = 16'hFFFF;
          4:       lam = 16'd1;
          5:       lam = 16'd512;
          7:       lam = LambdaReset;
          default: lam = $urandom_range(0, 65535);
        endcase
        write_lambda(lam);
      end
      idle_mode = phase % 4;
      sent      = 0;
      paused    = 1'b0;
      while (sent < 140) begin
        send_group(n);
        sent += n;
        if (!paused && sent >= 70) begin
          hold_until_drained();
          paused = 1'b1;
        end
      end
    end

    hold_until_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[quadtree_node_cost_merge.f]
rtl/qtncm_pkg.sv
rtl/qtncm_accum.sv
rtl/quadtree_node_cost_merge.sv
rtl/qtncm_checker.sv
tb/sv/quadtree_node_cost_merge_tb.sv
